@@ rtl/core/planar_to_chunky_color_map_assert.svh @@
// assertion macros for the planar to chunky color map checker
// no dependencies; the checker takes this file by include
`ifndef PLANAR_TO_CHUNKY_COLOR_MAP_ASSERT_SVH
`define PLANAR_TO_CHUNKY_COLOR_MAP_ASSERT_SVH

// property checked on every clock edge, disabled while reset is held
`define P2C_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked on every clock edge, reset included
`define P2C_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/p2c_pkg.sv @@
// shared types, constants and the color map function of the planar to chunky block
// no dependencies
`timescale 1ns / 1ps

package p2c_pkg;

  localparam int unsigned P2C_MAX_ROW_WIDTH = 256;
  localparam int unsigned P2C_GROUP_PIXELS  = 8;
  localparam int unsigned P2C_QUEUE_DEPTH   = 2;
  localparam int unsigned P2C_NUM_PLANES    = 4;

  localparam logic [8:0] P2C_ROW_WIDTH_RST = 9'd64;

  // legal palette values
  localparam logic [3:0] COLOR_DARK_PIECE   = 4'd0;
  localparam logic [3:0] COLOR_DARK_SQUARE  = 4'd2;
  localparam logic [3:0] COLOR_LIGHT_SQUARE = 4'd14;
  localparam logic [3:0] COLOR_LIGHT_PIECE  = 4'd15;

  // index codes
  localparam logic [1:0] IDX_DARK_PIECE   = 2'd0;
  localparam logic [1:0] IDX_DARK_SQUARE  = 2'd1;
  localparam logic [1:0] IDX_LIGHT_PIECE  = 2'd2;
  localparam logic [1:0] IDX_LIGHT_SQUARE = 2'd3;
  localparam logic [1:0] IDX_NONE         = 2'd0;

  // character codes
  localparam logic [6:0] CHAR_DARK_PIECE   = 7'h20;  // space
  localparam logic [6:0] CHAR_DARK_SQUARE  = 7'h2E;  // period
  localparam logic [6:0] CHAR_LIGHT_PIECE  = 7'h58;  // X
  localparam logic [6:0] CHAR_LIGHT_SQUARE = 7'h2A;  // asterisk
  localparam logic [6:0] CHAR_NONE         = 7'h00;

  // one classified column group, front to back
  typedef struct packed {
    logic [P2C_NUM_PLANES-1:0][7:0] planes;   // planes[j] is plane j
    logic [3:0]                     count;    // pixels to emit, 1..8
    logic                           ends_row;
  } group_t;

  typedef struct packed {
    logic [1:0] index_code;
    logic [6:0] char_code;
    logic       illegal;
  } pix_map_t;

  function automatic pix_map_t p2c_map_color(input logic [3:0] v);
    pix_map_t m;
    m.illegal = 1'b0;
    unique case (v)
      COLOR_DARK_PIECE: begin
        m.index_code = IDX_DARK_PIECE;
        m.char_code  = CHAR_DARK_PIECE;
      end
      COLOR_DARK_SQUARE: begin
        m.index_code = IDX_DARK_SQUARE;
        m.char_code  = CHAR_DARK_SQUARE;
      end
      COLOR_LIGHT_PIECE: begin
        m.index_code = IDX_LIGHT_PIECE;
        m.char_code  = CHAR_LIGHT_PIECE;
      end
      COLOR_LIGHT_SQUARE: begin
        m.index_code = IDX_LIGHT_SQUARE;
        m.char_code  = CHAR_LIGHT_SQUARE;
      end
      default: begin
        m.index_code = IDX_NONE;
        m.char_code  = CHAR_NONE;
        m.illegal    = 1'b1;
      end
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/p2c_if.sv @@
// channel interfaces of the planar to chunky block: groups, pixels, configuration
// no dependencies
`timescale 1ns / 1ps

interface p2c_grp_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane0_byte;
  logic [7:0] plane1_byte;
  logic [7:0] plane2_byte;
  logic [7:0] plane3_byte;

  modport source (output valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
                  input ready);
  modport sink   (input valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
                  output ready);
endinterface

interface p2c_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_value;
  logic [1:0] index_code;
  logic [6:0] char_code;
  logic       illegal_color;
  logic       row_end;
  logic       last_of_run;

  modport source (output valid, pixel_value, index_code, char_code, illegal_color,
                         row_end, last_of_run,
                  input ready);
  modport sink   (input valid, pixel_value, index_code, char_code, illegal_color,
                        row_end, last_of_run,
                  output ready);
endinterface

interface p2c_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] row_width;

  modport source (output valid, row_width, input ready);
  modport sink   (input valid, row_width, output ready);
endinterface

@@ rtl/core/planar_to_chunky_color_map.sv @@
// top level of the planar to chunky color map block
// depends on p2c_pkg, p2c_if, p2c_front, p2c_queue and p2c_back
`timescale 1ns / 1ps

// usage
//   grp_i: one beat is one column group of eight pixels as four plane bytes,
//     plane 0 giving the most significant bit, the byte msb giving the first pixel
//   pix_o: one beat per pixel, 1 to 8 beats per group, last_of_run on the final
//     one, row_end on the last pixel of an image row
//   cfg_i: writes row_width; always ready, meant to be written while idle
// with the queue empty, the first pixel of a group is made valid through the queue
//   write and then the pixel register
// throughput: one pixel per cycle while a group is queued and pix_o is ready; a group
//   emits 8 pixels, fewer at a row end; set by the back end emitting one pixel per cycle
// grp_i stays ready while the two-entry queue has room, so groups keep flowing
//   while a finished pixel waits at pix_o
// a stall on pix_o holds the pixel register, then backs up the queue and
//   finally drops grp_i.ready
// reset: row_width returns to 64, the column counter to zero and the queue empties;
//   no clearing pass is needed

module planar_to_chunky_color_map #(
  parameter int unsigned MAX_ROW_WIDTH = p2c_pkg::P2C_MAX_ROW_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  p2c_cfg_if.sink   cfg_i,
  p2c_grp_if.sink   grp_i,
  p2c_pix_if.source pix_o
);
  import p2c_pkg::*;

  // classified group on its way into the queue
  group_t push_grp;
  logic   push;
  logic   full;

  // queue head as seen by the back end
  group_t head;
  logic   head_valid;
  logic   pop;

  // front end: holds row width and column position, cuts groups at row end
  p2c_front #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_i),
    .grp     (grp_i),
    .full_i  (full),
    .push_o  (push),
    .group_o (push_grp)
  );

  // decoupling queue, lets front and back stall on their own
  p2c_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_grp),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head),
    .valid_o (head_valid)
  );

  // back end: one pixel per cycle from the queue head while pix_o is ready, popped on its last pixel
  p2c_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .pix          (pix_o)
  );

endmodule

@@ rtl/core/p2c_queue.sv @@
// short flip-flop queue of classified groups between front and back
// depends on p2c_pkg
`timescale 1ns / 1ps

module p2c_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  p2c_pkg::group_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output p2c_pkg::group_t data_o,
  output logic            valid_o
);
  import p2c_pkg::*;

  localparam int unsigned Depth = P2C_QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? bump(wptr_q) : wptr_q;
    rptr_d = pop_i  ? bump(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/p2c_front.sv @@
// front end: row width register, column counter and group classification
// depends on p2c_pkg and p2c_if
`timescale 1ns / 1ps

module p2c_front #(
  parameter int unsigned MAX_ROW_WIDTH = p2c_pkg::P2C_MAX_ROW_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  p2c_cfg_if.sink         cfg,
  p2c_grp_if.sink         grp,
  input  logic            full_i,
  output logic            push_o,
  output p2c_pkg::group_t group_o
);
  import p2c_pkg::*;

  // compare width covers both the 9-bit register and the largest row width
  localparam int unsigned CmpW = ($clog2(MAX_ROW_WIDTH + 1) > 9) ?
                                 $clog2(MAX_ROW_WIDTH + 1) : 9;
  localparam int unsigned ColW = $clog2(MAX_ROW_WIDTH);
  localparam logic [CmpW-1:0] MaxW   = CmpW'(MAX_ROW_WIDTH);
  localparam logic [CmpW-1:0] GrpPix = CmpW'(P2C_GROUP_PIXELS);

  logic [8:0]      row_width_q;
  logic [ColW-1:0] col_q, col_d;
  logic [CmpW-1:0] width_raw, width_eff, col_ext, col_eff, remain;
  logic            long_run;

  assign cfg.ready = 1'b1;
  assign grp.ready = !full_i;
  assign push_o    = grp.valid && !full_i;

  always_comb begin
    width_raw = CmpW'(row_width_q);
    if (width_raw == '0) begin
      width_eff = CmpW'(1);
    end else if (width_raw > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = width_raw;
    end
    // stale column after a width change starts a new row
    col_ext  = CmpW'(col_q);
    col_eff  = (col_ext >= width_eff) ? '0 : col_ext;
    remain   = width_eff - col_eff;
    long_run = (remain > GrpPix);

    group_o.planes[0] = grp.plane0_byte;
    group_o.planes[1] = grp.plane1_byte;
    group_o.planes[2] = grp.plane2_byte;
    group_o.planes[3] = grp.plane3_byte;
    group_o.count     = long_run ? 4'(P2C_GROUP_PIXELS) : remain[3:0];
    group_o.ends_row  = !long_run;

    col_d = col_q;
    if (push_o) begin
      col_d = long_run ? ColW'(col_eff + GrpPix) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= P2C_ROW_WIDTH_RST;
      col_q       <= '0;
    end else begin
      if (cfg.valid) begin
        row_width_q <= cfg.row_width;
      end
      col_q <= col_d;
    end
  end

endmodule

@@ rtl/core/p2c_back.sv @@
// back end: serializes the queue head into pixels and maps each through the color table
// depends on p2c_pkg and p2c_if
`timescale 1ns / 1ps

module p2c_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  p2c_pkg::group_t head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  p2c_pix_if.source       pix
);
  import p2c_pkg::*;

  logic [2:0] k_q, k_d;
  logic [2:0] sel;
  logic [3:0] value;
  logic       adv, last;
  pix_map_t   map;

  logic       valid_q;
  logic [3:0] value_q;
  pix_map_t   map_q;
  logic       row_end_q, last_q;

  always_comb begin
    adv   = head_valid_i && (!valid_q || pix.ready);
    last  = ({1'b0, k_q} + 4'd1) == head_i.count;
    pop_o = adv && last;
    sel   = ~k_q;  // pixel k takes bit 7-k
    value = {head_i.planes[0][sel], head_i.planes[1][sel],
             head_i.planes[2][sel], head_i.planes[3][sel]};
    map   = p2c_map_color(value);
    k_d   = k_q;
    if (adv) begin
      k_d = last ? '0 : k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (adv) begin
        valid_q <= 1'b1;
      end else if (pix.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_q   <= value;
      map_q     <= map;
      row_end_q <= last && head_i.ends_row;
      last_q    <= last;
    end
  end

  assign pix.valid         = valid_q;
  assign pix.pixel_value   = value_q;
  assign pix.index_code    = map_q.index_code;
  assign pix.char_code     = map_q.char_code;
  assign pix.illegal_color = map_q.illegal;
  assign pix.row_end       = row_end_q;
  assign pix.last_of_run   = last_q;

endmodule

@@ rtl/core/p2c_checker.sv @@
// port-level checker for the planar to chunky block, bound to the top level
// depends on p2c_pkg, planar_to_chunky_color_map_assert.svh and the top level
`timescale 1ns / 1ps
`include "planar_to_chunky_color_map_assert.svh"

module p2c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pix_valid_i,
  input logic       pix_ready_i,
  input logic [3:0] pixel_value_i,
  input logic [1:0] index_code_i,
  input logic [6:0] char_code_i,
  input logic       illegal_color_i,
  input logic       row_end_i,
  input logic       last_of_run_i
);
  import p2c_pkg::*;

  logic legal;
  assign legal = (pixel_value_i == COLOR_DARK_PIECE)   ||
                 (pixel_value_i == COLOR_DARK_SQUARE)  ||
                 (pixel_value_i == COLOR_LIGHT_SQUARE) ||
                 (pixel_value_i == COLOR_LIGHT_PIECE);

  // a stalled pixel stays put
  `P2C_ASSERT_RST(a_pix_hold, clk_i, rst_ni,
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pixel_value_i) &&
      $stable(row_end_i) && $stable(last_of_run_i),
    "stalled pixel changed")

  // a row always ends on the last pixel of a group
  `P2C_ASSERT_RST(a_row_end_last, clk_i, rst_ni,
    pix_valid_i && row_end_i |-> last_of_run_i,
    "row end without end of group")

  // illegal flag follows the raw value and zeroes both codes
  `P2C_ASSERT_RST(a_illegal_map, clk_i, rst_ni,
    pix_valid_i |-> (illegal_color_i == !legal) &&
      (!illegal_color_i || (index_code_i == IDX_NONE && char_code_i == CHAR_NONE)),
    "illegal color flag or codes wrong")

  // no pixel is offered on the edge after reset was seen
  `P2C_ASSERT_CLK(a_reset_quiet, clk_i,
    !rst_ni |=> !pix_valid_i,
    "pixel valid during reset")

endmodule

bind planar_to_chunky_color_map p2c_checker u_p2c_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pix_valid_i     (pix_o.valid),
  .pix_ready_i     (pix_o.ready),
  .pixel_value_i   (pix_o.pixel_value),
  .index_code_i    (pix_o.index_code),
  .char_code_i     (pix_o.char_code),
  .illegal_color_i (pix_o.illegal_color),
  .row_end_i       (pix_o.row_end),
  .last_of_run_i   (pix_o.last_of_run)
);
